### hdl/atsc_pkg.sv
// Shared types and codes for the atlas tile slot cache.
// Used by atsc_ctrl, atsc_dp and atlas_tile_slot_cache; no dependencies.
`default_nettype none
package atsc_pkg;

  localparam int KEY_ZOOM_W = 5;
  localparam int FMT_W      = 16;

  localparam logic [2:0] ACT_ALLOC  = 3'd0;
  localparam logic [2:0] ACT_LOOKUP = 3'd1;
  localparam logic [2:0] ACT_REMOVE = 3'd2;
  localparam logic [2:0] ACT_CLEAR  = 3'd3;
  localparam logic [2:0] ACT_SWEEP  = 3'd4;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_FOUND  = 2'd1,
    ST_NO_SLOT    = 2'd2,
    ST_BAD_FORMAT = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_LOAD,
    OP_ALLOC,
    OP_SCAN,
    OP_HIT_LOOKUP,
    OP_HIT_REMOVE,
    OP_CLEAR,
    OP_SWEEP,
    OP_DIV_A,
    OP_DIV_R,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t     op;
    status_t status;
    logic    report;
  } cmd_t;

  typedef struct packed {
    logic cfg_hit;
    logic init_last;
    logic fmt_ok;
    logic fifo_empty;
    logic scan_hit;
    logic scan_miss;
    logic sweep_last;
    logic div_a_more;
    logic div_r_more;
  } stat_t;

endpackage
`default_nettype wire

### hdl/atsc_dp.sv
// Datapath of the atlas tile slot cache: geometry registers, slot marks,
// key memory, free-slot FIFO memory, search, sweep and slot location.
// Depends on atsc_pkg.
`default_nettype none
module atsc_dp #(
  parameter int SLOTS      = 256,
  parameter int COORD_BITS = 22
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire atsc_pkg::cmd_t    cmd,
  output atsc_pkg::stat_t        stat,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_wdata,
  input  wire logic [4:0]        in_tile_zoom,
  input  wire logic [21:0]       in_tile_x,
  input  wire logic [21:0]       in_tile_y,
  input  wire logic [15:0]       in_image_format,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output logic [7:0]             out_slot,
  output logic [1:0]             out_atlas_index,
  output logic [5:0]             out_tile_row,
  output logic [5:0]             out_tile_column,
  output logic [8:0]             out_freed_count
);
  import atsc_pkg::*;

  localparam int SW    = $clog2(SLOTS);
  localparam int CW    = (COORD_BITS < 22) ? COORD_BITS : 22;
  localparam int KEY_W = KEY_ZOOM_W + 2 * CW;

  logic [6:0]  tpr_r, tpc_r;
  logic [2:0]  ac_r;
  logic [15:0] fmt_r;
  logic [6:0]  rs_r;
  logic [12:0] pa_r;
  logic [SW:0] total_r;

  logic [6:0]  rs_c, cs_c;
  logic [2:0]  ac_c;
  logic [12:0] pa_c;
  logic [14:0] tot_c;

  logic [KEY_W-1:0] key_mem [SLOTS];
  logic [SW-1:0]    fifo_mem [SLOTS];
  logic [SLOTS-1:0] occ_r, used_r;

  logic [SW-1:0]    head_r, init_idx_r, cmp_idx_r, fifo_rd_r, sel_r, rem_r;
  logic [SW:0]      cnt_r, scan_r, freed_r;
  logic             cmp_v_r;
  logic [KEY_W-1:0] key_rd_r, key_q_r, key_c;
  logic [15:0]      fmt_q_r;
  logic [1:0]       atl_r;
  logic [5:0]       row_r;

  logic             out_valid_r;
  logic [1:0]       out_status_r, out_atlas_r;
  logic [7:0]       out_slot_r;
  logic [5:0]       out_row_r, out_col_r;
  logic [8:0]       out_freed_r;

  logic [SW-1:0]    sweep_idx, free_s, tail, head_nxt;
  logic [SW:0]      tail_sum;
  logic             free_en, push_en;

  always_comb begin
    rs_c  = (tpr_r == 7'd0) ? 7'd1 : ((tpr_r > 7'd64) ? 7'd64 : tpr_r);
    cs_c  = (tpc_r == 7'd0) ? 7'd1 : ((tpc_r > 7'd64) ? 7'd64 : tpc_r);
    ac_c  = (ac_r == 3'd0) ? 3'd1 : ((ac_r > 3'd4) ? 3'd4 : ac_r);
    pa_c  = 13'(rs_c) * 13'(cs_c);
    tot_c = 15'(pa_c) * 15'(ac_c);
    key_c = {in_tile_zoom, in_tile_x[CW-1:0], in_tile_y[CW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpr_r <= 7'd8;
      tpc_r <= 7'd8;
      ac_r  <= 3'd1;
      fmt_r <= 16'd6408;
    end else if (cfg_we) begin
      unique case (cfg_index)
        2'd0: tpr_r <= cfg_wdata[6:0];
        2'd1: tpc_r <= cfg_wdata[6:0];
        2'd2: ac_r  <= cfg_wdata[2:0];
        2'd3: fmt_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rs_r    <= rs_c;
    pa_r    <= pa_c;
    total_r <= (32'(tot_c) > SLOTS) ? (SW+1)'(SLOTS) : (SW+1)'(tot_c);
  end

  always_comb begin
    sweep_idx = scan_r[SW-1:0];
    free_en   = (cmd.op == OP_HIT_REMOVE) ||
                ((cmd.op == OP_SWEEP) && occ_r[sweep_idx] && !used_r[sweep_idx]);
    free_s    = (cmd.op == OP_HIT_REMOVE) ? cmp_idx_r : sweep_idx;
    push_en   = free_en && (cnt_r < (SW+1)'(SLOTS));
    tail_sum  = (SW+1)'(head_r) + cnt_r;
    tail      = (tail_sum >= (SW+1)'(SLOTS)) ? SW'(tail_sum - (SW+1)'(SLOTS))
                                             : SW'(tail_sum);
    head_nxt  = (head_r == SW'(SLOTS - 1)) ? '0 : head_r + SW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_ALLOC) begin
      key_mem[fifo_rd_r] <= key_q_r;
    end
    key_rd_r <= key_mem[scan_r[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_INIT) begin
      fifo_mem[init_idx_r] <= init_idx_r;
    end else if (push_en) begin
      fifo_mem[tail] <= free_s;
    end
    fifo_rd_r <= fifo_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      occ_r  <= '0;
      used_r <= '0;
    end else begin
      case (cmd.op)
        OP_ALLOC: begin
          occ_r[fifo_rd_r]  <= 1'b1;
          used_r[fifo_rd_r] <= 1'b0;
        end
        OP_HIT_LOOKUP: used_r[cmp_idx_r] <= 1'b1;
        OP_CLEAR:      used_r <= '0;
        default: begin
          if (free_en) begin
            occ_r[free_s]  <= 1'b0;
            used_r[free_s] <= 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      head_r     <= '0;
      cnt_r      <= '0;
      init_idx_r <= '0;
    end else begin
      if (cmd.op == OP_INIT) begin
        init_idx_r <= init_idx_r + SW'(1);
        if (init_idx_r == SW'(SLOTS - 1)) begin
          cnt_r <= total_r;
        end
      end else if (cmd.op == OP_ALLOC) begin
        head_r <= head_nxt;
        cnt_r  <= cnt_r - (SW+1)'(1);
      end else if (push_en) begin
        cnt_r <= cnt_r + (SW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_v_r <= 1'b0;
      scan_r  <= '0;
      freed_r <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          key_q_r <= key_c;
          fmt_q_r <= in_image_format;
          scan_r  <= '0;
          cmp_v_r <= 1'b0;
          freed_r <= '0;
        end
        OP_SCAN: begin
          if (scan_r < (SW+1)'(SLOTS)) begin
            cmp_idx_r <= scan_r[SW-1:0];
            cmp_v_r   <= 1'b1;
            scan_r    <= scan_r + (SW+1)'(1);
          end else begin
            cmp_v_r <= 1'b0;
          end
        end
        OP_SWEEP: begin
          scan_r <= scan_r + (SW+1)'(1);
          if (free_en) begin
            freed_r <= freed_r + (SW+1)'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ALLOC: begin
        sel_r <= fifo_rd_r;
        rem_r <= fifo_rd_r;
        atl_r <= '0;
        row_r <= '0;
      end
      OP_HIT_LOOKUP: begin
        sel_r <= cmp_idx_r;
        rem_r <= cmp_idx_r;
        atl_r <= '0;
        row_r <= '0;
      end
      OP_DIV_A: begin
        rem_r <= rem_r - SW'(pa_r);
        atl_r <= atl_r + 2'd1;
      end
      OP_DIV_R: begin
        rem_r <= rem_r - SW'(rs_r);
        row_r <= row_r + 6'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == OP_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FINISH) begin
      out_status_r <= cmd.status;
      out_freed_r  <= 9'(freed_r);
      out_slot_r   <= cmd.report ? 8'(sel_r) : '0;
      out_atlas_r  <= cmd.report ? atl_r : '0;
      out_row_r    <= cmd.report ? row_r : '0;
      out_col_r    <= cmd.report ? 6'(rem_r) : '0;
    end
  end

  always_comb begin
    stat.cfg_hit    = cfg_we;
    stat.init_last  = (init_idx_r == SW'(SLOTS - 1));
    stat.fmt_ok     = (fmt_q_r == fmt_r);
    stat.fifo_empty = (cnt_r == '0);
    stat.scan_hit   = cmp_v_r && occ_r[cmp_idx_r] && (key_rd_r == key_q_r);
    stat.scan_miss  = !cmp_v_r && (scan_r == (SW+1)'(SLOTS));
    stat.sweep_last = (sweep_idx == SW'(SLOTS - 1));
    stat.div_a_more = (32'(rem_r) >= 32'(pa_r));
    stat.div_r_more = (32'(rem_r) >= 32'(rs_r));
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot        = out_slot_r;
  assign out_atlas_index = out_atlas_r;
  assign out_tile_row    = out_row_r;
  assign out_tile_column = out_col_r;
  assign out_freed_count = out_freed_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (SW+1)'(SLOTS))
    else $error("free count above slot total");
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");
  a_alloc_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_ALLOC) |-> (cnt_r != '0))
    else $error("allocate from empty free list");
  a_hit_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_HIT_REMOVE) |=> !occ_r[$past(cmp_idx_r)])
    else $error("removed slot still occupied");

endmodule
`default_nettype wire

### hdl/atsc_ctrl.sv
// Controller of the atlas tile slot cache: sequences init, allocate,
// search, sweep, slot location and result issue. Depends on atsc_pkg.
`default_nettype none
module atsc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [2:0]      in_action,
  input  wire atsc_pkg::stat_t stat,
  output atsc_pkg::cmd_t       cmd,
  output logic                 busy
);
  import atsc_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_ALLOC, S_SCAN, S_CLEAR, S_SWEEP, S_DIV_A, S_DIV_R, S_DONE
  } state_t;

  state_t     state_r;
  logic [2:0] action_r;
  status_t    status_r;
  logic       report_r;

  always_comb begin
    cmd.op     = OP_NONE;
    cmd.status = status_r;
    cmd.report = report_r;
    unique case (state_r)
      S_INIT:  cmd.op = OP_INIT;
      S_IDLE:  cmd.op = start ? OP_LOAD : OP_NONE;
      S_ALLOC: cmd.op = (stat.fmt_ok && !stat.fifo_empty) ? OP_ALLOC : OP_NONE;
      S_SCAN: begin
        if (stat.scan_hit) begin
          cmd.op = (action_r == ACT_LOOKUP) ? OP_HIT_LOOKUP : OP_HIT_REMOVE;
        end else if (!stat.scan_miss) begin
          cmd.op = OP_SCAN;
        end
      end
      S_CLEAR: cmd.op = OP_CLEAR;
      S_SWEEP: cmd.op = OP_SWEEP;
      S_DIV_A: cmd.op = stat.div_a_more ? OP_DIV_A : OP_NONE;
      S_DIV_R: cmd.op = stat.div_r_more ? OP_DIV_R : OP_NONE;
      S_DONE:  cmd.op = OP_FINISH;
      default: cmd.op = OP_NONE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      action_r <= ACT_ALLOC;
      status_r <= ST_OK;
      report_r <= 1'b0;
    end else if (stat.cfg_hit) begin
      state_r <= S_INIT;
    end else begin
      unique case (state_r)
        S_INIT: begin
          if (stat.init_last) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            action_r <= in_action;
            status_r <= ST_OK;
            report_r <= 1'b0;
            case (in_action) inside
              ACT_ALLOC:              state_r <= S_ALLOC;
              ACT_LOOKUP, ACT_REMOVE: state_r <= S_SCAN;
              ACT_CLEAR:              state_r <= S_CLEAR;
              ACT_SWEEP:              state_r <= S_SWEEP;
              default: begin
                status_r <= ST_NOT_FOUND;
                state_r  <= S_DONE;
              end
            endcase
          end
        end
        S_ALLOC: begin
          if (!stat.fmt_ok) begin
            status_r <= ST_BAD_FORMAT;
            state_r  <= S_DONE;
          end else if (stat.fifo_empty) begin
            status_r <= ST_NO_SLOT;
            state_r  <= S_DONE;
          end else begin
            state_r <= S_DIV_A;
          end
        end
        S_SCAN: begin
          if (stat.scan_hit) begin
            state_r <= (action_r == ACT_LOOKUP) ? S_DIV_A : S_DONE;
          end else if (stat.scan_miss) begin
            status_r <= ST_NOT_FOUND;
            state_r  <= S_DONE;
          end
        end
        S_CLEAR: state_r <= S_DONE;
        S_SWEEP: begin
          if (stat.sweep_last) state_r <= S_DONE;
        end
        S_DIV_A: begin
          if (!stat.div_a_more) state_r <= S_DIV_R;
        end
        S_DIV_R: begin
          if (!stat.div_r_more) begin
            report_r <= 1'b1;
            state_r  <= S_DONE;
          end
        end
        S_DONE:  state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !stat.cfg_hit) |=> busy)
    else $error("accepted transaction without going busy");
  a_finish_once: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_FINISH && !stat.cfg_hit) |=> !busy)
    else $error("not idle after result");
  a_report_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_FINISH && cmd.report) |-> (cmd.status == ST_OK))
    else $error("slot reported on failure");

endmodule
`default_nettype wire

### hdl/atlas_tile_slot_cache.sv
// Top level of the atlas tile slot cache: controller plus datapath.
// Depends on atsc_pkg, atsc_ctrl and atsc_dp.
//
// A transaction is taken when start is high and busy is low; its single
// result appears on the out_ ports for one cycle with out_valid, and the
// receiver cannot stall it. After reset and after every configuration write
// the block runs an init pass that refills the free-slot FIFO and drops
// every tile. Allocate checks the format and a free slot, then does slot
// location; lookup and remove scan the key memory one slot a cycle, and a
// lookup hit then pays for slot location; sweep walks all SLOTS slots. Slot
// location subtracts first the atlas size, then the row length, one
// subtraction a cycle.
`default_nettype none
module atlas_tile_slot_cache #(
  parameter int SLOTS      = 256,
  parameter int COORD_BITS = 22
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_action,
  input  wire logic [4:0]  in_tile_zoom,
  input  wire logic [21:0] in_tile_x,
  input  wire logic [21:0] in_tile_y,
  input  wire logic [15:0] in_image_format,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [7:0]       out_slot,
  output logic [1:0]       out_atlas_index,
  output logic [5:0]       out_tile_row,
  output logic [5:0]       out_tile_column,
  output logic [8:0]       out_freed_count,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  import atsc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  atsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  atsc_dp #(
    .SLOTS      (SLOTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_tile_zoom    (in_tile_zoom),
    .in_tile_x       (in_tile_x),
    .in_tile_y       (in_tile_y),
    .in_image_format (in_image_format),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_atlas_index (out_atlas_index),
    .out_tile_row    (out_tile_row),
    .out_tile_column (out_tile_column),
    .out_freed_count (out_freed_count)
  );

endmodule
`default_nettype wire

### bench/testbench.sv
// Self-checking bench for atlas_tile_slot_cache: directed table, then random traffic.
// Depends on atsc_pkg and the atlas_tile_slot_cache RTL; expected results come
// from a behavioral slot-cache predictor kept inside the bench.
`timescale 1ns / 100ps
module testbench;
  import atsc_pkg::*;

  typedef struct {
    status_t    status;
    logic [7:0] slot;
    logic [1:0] atlas;
    logic [5:0] row;
    logic [5:0] col;
    logic [8:0] freed;
  } slot_report_t;

  typedef struct {
    logic [2:0]   act;
    logic [4:0]   zoom;
    logic [21:0]  x;
    logic [21:0]  y;
    logic [15:0]  fmt;
    bit           typed;
    slot_report_t want;
  } table_row_t;

  localparam int NSLOT = 256;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PEND_DEPTH = 16;
  localparam int POOL_SIZE = 12;
  localparam logic [1:0] REG_ROW = 2'd0, REG_COL = 2'd1, REG_ATLAS = 2'd2, REG_FMT = 2'd3;

  logic clk = 1'b0, rst_n = 1'b0, start = 1'b0, busy;
  logic [2:0] in_action = '0;
  logic [4:0] in_tile_zoom = '0;
  logic [21:0] in_tile_x = '0, in_tile_y = '0;
  logic [15:0] in_image_format = '0;
  logic out_valid;
  logic [1:0] out_status, out_atlas_index;
  logic [7:0] out_slot;
  logic [5:0] out_tile_row, out_tile_column;
  logic [8:0] out_freed_count;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  atlas_tile_slot_cache DUT (
    .clk, .rst_n, .start, .busy, .in_action, .in_tile_zoom, .in_tile_x, .in_tile_y,
    .in_image_format, .out_valid, .out_status, .out_slot, .out_atlas_index,
    .out_tile_row, .out_tile_column, .out_freed_count, .cfg_we, .cfg_index, .cfg_wdata
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // cache shadow
  logic [48:0] key_mem [NSLOT];
  bit          occ [NSLOT];
  bit          used [NSLOT];
  logic [7:0]  free_fifo [NSLOT];
  int          fifo_head, fifo_count;
  logic [6:0]  reg_row = 7'd8, reg_col = 7'd8;
  logic [2:0]  reg_atlas = 3'd1;
  logic [15:0] reg_fmt = 16'd6408;

  slot_report_t pend_mem [PEND_DEPTH];
  int pend_rd = 0, pend_wr = 0;
  int errors = 0, accepted = 0, checked = 0, sweeps_freed = 0, no_slot_seen = 0;
  int watchdog = 0;
  bit no_idle = 0;
  logic [48:0] key_pool [POOL_SIZE];
  slot_report_t none_ok = '{ST_OK, 8'd0, 2'd0, 6'd0, 6'd0, 9'd0};
  slot_report_t miss = '{ST_NOT_FOUND, 8'd0, 2'd0, 6'd0, 6'd0, 9'd0};
  slot_report_t bad_fmt = '{ST_BAD_FORMAT, 8'd0, 2'd0, 6'd0, 6'd0, 9'd0};

  function automatic int pend_level();
    return pend_wr - pend_rd;
  endfunction

  function automatic int sat(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int row_len();
    return sat(reg_row, 1, 64);
  endfunction

  function automatic int atlas_size();
    return row_len() * sat(reg_col, 1, 64);
  endfunction

  function automatic void cache_reinit();
    int total;
    total = atlas_size() * sat(reg_atlas, 1, 4);
    if (total > NSLOT) total = NSLOT;
    for (int i = 0; i < NSLOT; i++) begin
      occ[i] = 0;
      used[i] = 0;
      free_fifo[i] = i < total ? i[7:0] : 8'd0;
    end
    fifo_head = 0;
    fifo_count = total;
  endfunction

  function automatic void release_slot(int s);
    occ[s] = 0;
    used[s] = 0;
    if (fifo_count < NSLOT) begin
      free_fifo[(fifo_head + fifo_count) % NSLOT] = s[7:0];
      fifo_count++;
    end
  endfunction

  function automatic int find_slot(logic [48:0] k);
    for (int s = 0; s < NSLOT; s++)
      if (occ[s] && key_mem[s] == k) return s;
    return -1;
  endfunction

  function automatic slot_report_t place_slot(int s);
    slot_report_t r;
    int offset;
    offset = s % atlas_size();
    r = '{ST_OK, s[7:0], 2'((s / atlas_size()) & 3), 6'(offset / row_len()),
          6'(offset % row_len()), 9'd0};
    return r;
  endfunction

  function automatic slot_report_t cache_step(logic [2:0] act, logic [4:0] zoom,
                                               logic [21:0] x, logic [21:0] y,
                                               logic [15:0] fmt);
    slot_report_t r;
    logic [48:0] k;
    int s, n;
    r = '{ST_OK, 8'd0, 2'd0, 6'd0, 6'd0, 9'd0};
    k = {zoom, x, y};
    case (act)
      ACT_ALLOC: begin
        if (fmt != reg_fmt) r.status = ST_BAD_FORMAT;
        else if (fifo_count == 0) r.status = ST_NO_SLOT;
        else begin
          s = free_fifo[fifo_head];
          fifo_head = (fifo_head + 1) % NSLOT;
          fifo_count--;
          key_mem[s] = k;
          occ[s] = 1;
          used[s] = 0;
          r = place_slot(s);
        end
      end
      ACT_LOOKUP: begin
        s = find_slot(k);
        if (s < 0) r.status = ST_NOT_FOUND;
        else begin
          used[s] = 1;
          r = place_slot(s);
        end
      end
      ACT_REMOVE: begin
        s = find_slot(k);
        if (s < 0) r.status = ST_NOT_FOUND;
        else release_slot(s);
      end
      ACT_CLEAR: for (int i = 0; i < NSLOT; i++) used[i] = 0;
      ACT_SWEEP: begin
        n = 0;
        for (int i = 0; i < NSLOT; i++)
          if (occ[i] && !used[i]) begin
            release_slot(i);
            n++;
          end
        r.freed = n[8:0];
      end
      default: r.status = ST_NOT_FOUND;
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    slot_report_t w;
    if (rst_n && ((start && !busy) || out_valid)) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no transaction for %0d cycles", $time, watchdog);
      $display("[FAIL] regression broken");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (pend_level() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual status %0d", $time, out_status);
      end else begin
        w = pend_mem[pend_rd % PEND_DEPTH];
        pend_rd++;
        checked++;
        check_field("status", w.status, out_status);
        check_field("slot", w.slot, out_slot);
        check_field("atlas_index", w.atlas, out_atlas_index);
        check_field("tile_row", w.row, out_tile_row);
        check_field("tile_column", w.col, out_tile_column);
        check_field("freed_count", w.freed, out_freed_count);
      end
    end
  end

  function automatic int pick_gap();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic issue(logic [2:0] act, logic [4:0] zoom, logic [21:0] x, logic [21:0] y,
                       logic [15:0] fmt, bit typed, slot_report_t want);
    slot_report_t got;
    int gap;
    in_action <= act;
    in_tile_zoom <= zoom;
    in_tile_x <= x;
    in_tile_y <= y;
    in_image_format <= fmt;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    accepted++;
    got = cache_step(act, zoom, x, y, fmt);
    if (got.status == ST_NO_SLOT) no_slot_seen++;
    sweeps_freed += got.freed;
    pend_mem[pend_wr % PEND_DEPTH] = typed ? want : got;
    pend_wr++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pend_level() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_geometry(logic [6:0] r, logic [6:0] c, logic [2:0] a, logic [15:0] f);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= REG_ROW;
    cfg_wdata <= (16'($urandom) & 16'hFF80) | {9'd0, r};
    @(posedge clk);
    cfg_index <= REG_COL;
    cfg_wdata <= (16'($urandom) & 16'hFF80) | {9'd0, c};
    @(posedge clk);
    cfg_index <= REG_ATLAS;
    cfg_wdata <= (16'($urandom) & 16'hFFF8) | {13'd0, a};
    @(posedge clk);
    cfg_index <= REG_FMT;
    cfg_wdata <= f;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_row = r;
    reg_col = c;
    reg_atlas = a;
    reg_fmt = f;
    cache_reinit();
    repeat (2) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    logic [48:0] k;
    int p;
    logic [2:0] act;
    logic [15:0] fmt;
    for (int i = 0; i < POOL_SIZE; i++)
      key_pool[i] = {5'($urandom_range(31)), 22'($urandom), 22'($urandom)};
    no_idle = ($urandom_range(3) == 0);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) no_idle = !no_idle;
      p = $urandom_range(99);
      if (p < 38) act = ACT_ALLOC;
      else if (p < 65) act = ACT_LOOKUP;
      else if (p < 82) act = ACT_REMOVE;
      else if (p < 88) act = ACT_CLEAR;
      else if (p < 95) act = ACT_SWEEP;
      else act = 3'($urandom_range(7, 5));
      if ($urandom_range(9) == 0) k = {5'($urandom), 22'($urandom), 22'($urandom)};
      else k = key_pool[$urandom_range(POOL_SIZE - 1)];
      fmt = ($urandom_range(9) < 8) ? reg_fmt : 16'($urandom);
      issue(act, k[48:44], k[43:22], k[21:0], fmt, 0, none_ok);
    end
  endtask

  table_row_t plan[$];
  logic [6:0] geo_row[8] = '{7'd1, 7'd0, 7'd127, 7'd3, 7'd64, 7'd7, 7'd2, 7'd8};
  logic [6:0] geo_col[8] = '{7'd1, 7'd0, 7'd127, 7'd5, 7'd1, 7'd2, 7'd2, 7'd8};
  logic [2:0] geo_atl[8] = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd4, 3'd3, 3'd1, 3'd1};

  initial begin
    plan = '{
      '{ACT_LOOKUP, 5'd0, 22'd0, 22'd0, 16'd0, 1, miss},
      '{ACT_ALLOC, 5'd0, 22'd0, 22'd0, 16'd0, 1, bad_fmt},
      '{ACT_ALLOC, 5'd0, 22'd0, 22'd0, 16'hFFFF, 1, bad_fmt},
      '{ACT_ALLOC, 5'd31, 22'h3FFFFF, 22'h3FFFFF, 16'd6408, 1, none_ok},
      '{ACT_ALLOC, 5'd0, 22'd0, 22'd0, 16'd6408, 0, none_ok},
      '{ACT_ALLOC, 5'd31, 22'h3FFFFF, 22'h3FFFFF, 16'd6408, 0, none_ok},
      '{ACT_ALLOC, 5'd22, 22'h2AAAAA, 22'h155555, 16'd6408, 0, none_ok},
      '{ACT_LOOKUP, 5'd31, 22'h3FFFFF, 22'h3FFFFF, 16'd0, 0, none_ok},
      '{ACT_LOOKUP, 5'd22, 22'h2AAAAA, 22'h155555, 16'd0, 0, none_ok},
      '{ACT_LOOKUP, 5'd22, 22'h155555, 22'h2AAAAA, 16'd0, 0, none_ok},
      '{ACT_REMOVE, 5'd31, 22'h3FFFFF, 22'h3FFFFF, 16'd0, 0, none_ok},
      '{ACT_LOOKUP, 5'd31, 22'h3FFFFF, 22'h3FFFFF, 16'd0, 0, none_ok},
      '{ACT_REMOVE, 5'd1, 22'd1, 22'd1, 16'd0, 1, miss},
      '{ACT_SWEEP, 5'd0, 22'd0, 22'd0, 16'd0, 0, none_ok},
      '{ACT_CLEAR, 5'd0, 22'd0, 22'd0, 16'd0, 0, none_ok},
      '{ACT_SWEEP, 5'd0, 22'd0, 22'd0, 16'd0, 0, none_ok},
      '{ACT_SWEEP, 5'd0, 22'd0, 22'd0, 16'd0, 0, none_ok},
      '{3'd5, 5'd3, 22'd3, 22'd3, 16'd6408, 1, miss},
      '{3'd6, 5'd0, 22'd0, 22'd0, 16'd0, 1, miss},
      '{3'd7, 5'd31, 22'h3FFFFF, 22'h3FFFFF, 16'hFFFF, 1, miss}
    };
    cache_reinit();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (plan[i])
      issue(plan[i].act, plan[i].zoom, plan[i].x, plan[i].y, plan[i].fmt,
            plan[i].typed, plan[i].want);
    random_phase(200);
    for (int g = 0; g < 8; g++) begin
      write_geometry(geo_row[g], geo_col[g], geo_atl[g],
                     g == 0 ? 16'd0 : (g == 2 ? 16'hFFFF : (g == 7 ? 16'd6408
                                                                  : 16'($urandom))));
      random_phase(225);
    end
    settle();
    repeat (400) @(posedge clk);
    $display("Covered %0d transactions over 9 geometries, %0d results checked.",
             accepted, checked);
    $display("Sweeps freed %0d slots; %0d allocates hit a full cache.",
             sweeps_freed, no_slot_seen);
    if (errors == 0 && pend_level() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
